// ===== hw/rtl/ssdc_pkg.sv =====
package ssdc_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxBits = 3;
  localparam logic [CfgIdxBits-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_MIN_DIST = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_MAX_DIST = 3'd4;

  // Result classification codes.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_MIN  = 2'd1;
  localparam logic [1:0] KIND_MAX  = 2'd2;
  localparam logic [1:0] KIND_ZERO = 2'd3;

  // Outer radius after reset, in whole units.
  localparam int unsigned MaxResetUnits = 100;

endpackage

// ===== hw/rtl/ssdc_cfg_if.sv =====
interface ssdc_cfg_if
  import ssdc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 24
) ();
  logic                  valid;
  logic                  ready;
  logic [CfgIdxBits-1:0] index;
  logic [COORD_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/ssdc_pos_if.sv =====
interface ssdc_pos_if #(
  parameter int unsigned COORD_BITS = 24
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// ===== hw/rtl/ssdc_res_if.sv =====
interface ssdc_res_if #(
  parameter int unsigned COORD_BITS = 24
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic signed [COORD_BITS-1:0] out_z;
  logic [1:0]                   clamp_kind;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output clamp_kind, input ready);
  modport sink (input valid, input out_x, input out_y, input out_z,
                input clamp_kind, output ready);
endinterface

// ===== hw/rtl/spherical_shell_distance_clamp.sv =====
// Spherical shell distance clamp.
// Positions arrive on pos_i, one (x, y, z) triple per transfer, and leave on
// res_o with a clamp_kind code. The shell center and the two radii are written
// on cfg_i, which is always ready; write it only while no position is in flight.
// Every position gives exactly one result, in order.
// A position passes through stages A, B and C, the square root chain, the
// division chain and the output register. Throughput is one position per cycle
// while res_o is not stalled. The length is a floored square root taken one
// result bit per stage, and each scaled coordinate is a restoring division
// taking one quotient bit per stage; those two chains set the depth.
// When res_o is stalled the whole pipeline holds and pos_i.ready drops, so no
// item is dropped or repeated; a new position is still accepted in a cycle in
// which the finished result is taken.
// Reset clears all valid bits, sets the center and inner radius to zero and the
// outer radius to 100 units.
module spherical_shell_distance_clamp
  import ssdc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssdc_cfg_if.sink   cfg_i,
  ssdc_pos_if.sink   pos_i,
  ssdc_res_if.source res_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned R  = COORD_BITS - 1;   // radius and quotient width
  localparam int unsigned NB = 2 * C + 2;        // squared length width
  localparam int unsigned RW = C + 4;            // root remainder width
  localparam int unsigned DW = 2 * C;            // dividend width
  localparam int unsigned SQ = C + 1;            // root bits
  localparam logic [R-1:0] MaxReset = R'(MaxResetUnits << FRAC_BITS);
  localparam logic signed [C+1:0] SatHi = {3'b000, {(C-1){1'b1}}};
  localparam logic signed [C+1:0] SatLo = {3'b111, {(C-1){1'b0}}};

  typedef struct packed {
    logic [2:0][C-1:0] pos;
    logic [2:0]        neg;
    logic [2:0][C-1:0] mag;
    logic [1:0]        kind;
    logic [R-1:0]      radius;
  } carry_t;

  // Configuration.
  logic [2:0][C-1:0] center_q;
  logic [R-1:0]      min_q, max_q;
  logic [2*R-1:0]    min_sq_q, max_sq_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      min_q    <= '0;
      max_q    <= MaxReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_CENTER_X: center_q[0] <= cfg_i.data;
        REG_CENTER_Y: center_q[1] <= cfg_i.data;
        REG_CENTER_Z: center_q[2] <= cfg_i.data;
        REG_MIN_DIST: min_q <= cfg_i.data[R-1:0];
        REG_MAX_DIST: max_q <= cfg_i.data[R-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    min_sq_q <= min_q * min_q;
    max_sq_q <= max_q * max_q;
  end

  // Whole-pipeline advance.
  logic en;
  logic o_v_q;
  assign en          = !o_v_q || res_o.ready;
  assign pos_i.ready = en;

  // Stage A: offsets from the center.
  logic   a_v_q;
  carry_t a_c_d, a_c_q;
  always_comb begin
    logic [2:0][C-1:0] p;
    logic [C:0]        d;
    p = {pos_i.pos_z, pos_i.pos_y, pos_i.pos_x};
    a_c_d = '0;
    for (int a = 0; a < 3; a++) begin
      d = {p[a][C-1], p[a]} - {center_q[a][C-1], center_q[a]};
      a_c_d.pos[a] = p[a];
      a_c_d.neg[a] = d[C];
      a_c_d.mag[a] = d[C] ? C'(-d) : d[C-1:0];
    end
  end

  // Stage B: squares.
  logic              b_v_q;
  carry_t            b_c_q;
  logic [2:0][DW-1:0] b_sq_q;
  // Stage C: squared length.
  logic              c_v_q;
  carry_t            c_c_q;
  logic [NB-1:0]     c_d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= pos_i.valid;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_c_q <= a_c_d;
      b_c_q <= a_c_q;
      for (int a = 0; a < 3; a++) begin
        b_sq_q[a] <= a_c_q.mag[a] * a_c_q.mag[a];
      end
      c_c_q  <= b_c_q;
      c_d2_q <= NB'(b_sq_q[0]) + NB'(b_sq_q[1]) + NB'(b_sq_q[2]);
    end
  end

  // Square root chain; index 0 also classifies the item.
  logic          s_v_q    [0:SQ];
  carry_t        s_c_q    [0:SQ];
  logic [NB-1:0] s_n_q    [0:SQ];
  logic [RW-1:0] s_rem_q  [0:SQ];
  logic [C:0]    s_root_q [0:SQ];

  carry_t s0_c_d;
  always_comb begin
    s0_c_d = c_c_q;
    if (c_d2_q == '0) begin
      s0_c_d.kind = KIND_ZERO;
    end else if (c_d2_q < NB'(min_sq_q)) begin
      s0_c_d.kind = KIND_MIN;
    end else if (c_d2_q > NB'(max_sq_q)) begin
      s0_c_d.kind = KIND_MAX;
    end else begin
      s0_c_d.kind = KIND_NONE;
    end
    s0_c_d.radius = (s0_c_d.kind == KIND_MAX) ? max_q : min_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q[0] <= 1'b0;
    end else if (en) begin
      s_v_q[0] <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_c_q[0]    <= s0_c_d;
      s_n_q[0]    <= c_d2_q;
      s_rem_q[0]  <= '0;
      s_root_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [RW-1:0] rem_sh, trial;
    logic          ge;
    assign rem_sh = {s_rem_q[k][RW-3:0], s_n_q[k][NB-1 -: 2]};
    assign trial  = RW'({s_root_q[k], 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_v_q[k+1] <= 1'b0;
      end else if (en) begin
        s_v_q[k+1] <= s_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        s_c_q[k+1]    <= s_c_q[k];
        s_n_q[k+1]    <= s_n_q[k] << 2;
        s_rem_q[k+1]  <= ge ? rem_sh - trial : rem_sh;
        s_root_q[k+1] <= {s_root_q[k][C-1:0], ge};
      end
    end
  end

  // Division chain; index 0 holds the products offset times radius.
  logic               v_v_q   [0:R];
  carry_t             v_c_q   [0:R];
  logic [C:0]         v_len_q [0:R];
  logic [2:0][DW-1:0] v_rem_q [0:R];
  logic [2:0][R-1:0]  v_quo_q [0:R];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_v_q[0] <= 1'b0;
    end else if (en) begin
      v_v_q[0] <= s_v_q[SQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_c_q[0]   <= s_c_q[SQ];
      v_len_q[0] <= s_root_q[SQ];
      v_quo_q[0] <= '0;
      for (int a = 0; a < 3; a++) begin
        v_rem_q[0][a] <= DW'(s_c_q[SQ].mag[a]) * DW'(s_c_q[SQ].radius);
      end
    end
  end

  for (genvar j = 0; j < R; j++) begin : g_div
    localparam int unsigned Sh = R - 1 - j;
    logic [DW-1:0]      shifted;
    logic [2:0]         ge;
    logic [2:0][DW-1:0] rem_d;
    logic [2:0][R-1:0]  quo_d;
    assign shifted = DW'(v_len_q[j]) << Sh;

    always_comb begin
      for (int a = 0; a < 3; a++) begin
        ge[a]    = v_rem_q[j][a] >= shifted;
        rem_d[a] = ge[a] ? v_rem_q[j][a] - shifted : v_rem_q[j][a];
        quo_d[a] = {v_quo_q[j][a][R-2:0], ge[a]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_v_q[j+1] <= 1'b0;
      end else if (en) begin
        v_v_q[j+1] <= v_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        v_c_q[j+1]   <= v_c_q[j];
        v_len_q[j+1] <= v_len_q[j];
        v_rem_q[j+1] <= rem_d;
        v_quo_q[j+1] <= quo_d;
      end
    end
  end

  // Output stage: place a clamped point on the shell and saturate; others pass unchanged.
  carry_t            fc;
  logic              clamp;
  logic [2:0][C-1:0] out_d;
  assign fc    = v_c_q[R];
  assign clamp = (fc.kind == KIND_MIN) || (fc.kind == KIND_MAX);

  always_comb begin
    logic signed [C+1:0] qs, sum;
    for (int a = 0; a < 3; a++) begin
      qs  = {3'b000, v_quo_q[R][a]};
      sum = {{2{center_q[a][C-1]}}, center_q[a]} + (fc.neg[a] ? -qs : qs);
      if (!clamp) begin
        out_d[a] = fc.pos[a];
      end else if (sum > SatHi) begin
        out_d[a] = SatHi[C-1:0];
      end else if (sum < SatLo) begin
        out_d[a] = SatLo[C-1:0];
      end else begin
        out_d[a] = sum[C-1:0];
      end
    end
  end

  logic [2:0][C-1:0] o_pos_q;
  logic [1:0]        o_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (en) begin
      o_v_q <= v_v_q[R];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_pos_q  <= out_d;
      o_kind_q <= fc.kind;
    end
  end

  assign res_o.valid      = o_v_q;
  assign res_o.out_x      = o_pos_q[0];
  assign res_o.out_y      = o_pos_q[1];
  assign res_o.out_z      = o_pos_q[2];
  assign res_o.clamp_kind = o_kind_q;

  // A stalled pipeline must not move its items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(s_v_q[SQ]) && $stable(v_v_q[R]) && $stable(o_v_q))
    else $error("pipeline moved during a stall");

  // The root remainder stays within the floor square root bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_v_q[SQ] |-> s_rem_q[SQ] <= RW'({s_root_q[SQ], 1'b0}))
    else $error("square root remainder out of range");

  // Clamped items leave the divider with remainders below the length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_v_q[R] && clamp |-> v_rem_q[R][0] < DW'(v_len_q[R]) &&
      v_rem_q[R][1] < DW'(v_len_q[R]) && v_rem_q[R][2] < DW'(v_len_q[R]))
    else $error("division remainder out of range");

endmodule
